// ===== hdl/ost_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Occupancy sequence tracker package
// Event codes, presence and stage codes, register indexes and the state
// record shared by the tracker modules.
// ----------------------------------------------------------------------------
package ost_pkg;

    localparam int unsigned WIN_W  = 31;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned IDX_W  = 3;

    typedef enum logic [2:0] {
        MODE_TICK       = 3'd0,
        MODE_UNLOCK     = 3'd1,
        MODE_ULTRASONIC = 3'd2,
        MODE_OPEN       = 3'd3,
        MODE_CLOSE      = 3'd4,
        MODE_MOTION     = 3'd5,
        MODE_EXT_SET    = 3'd6
    } ost_mode_t;

    typedef enum logic [1:0] {
        PRES_UNKNOWN = 2'd0,
        PRES_HOME    = 2'd1,
        PRES_AWAY    = 2'd2
    } ost_presence_t;

    typedef enum logic [1:0] {
        ENTRY_IDLE       = 2'd0,
        ENTRY_WAIT_SENSE = 2'd1,
        ENTRY_WAIT_MOTION = 2'd2
    } ost_entry_t;

    typedef enum logic [1:0] {
        EXIT_IDLE       = 2'd0,
        EXIT_SAW_SENSE  = 2'd1,
        EXIT_DOOR_OPEN  = 2'd2,
        EXIT_WAIT_QUIET = 2'd3
    } ost_exit_t;

    localparam logic [IDX_W-1:0] CFG_UNLOCK_TO_SENSE = 3'd0;
    localparam logic [IDX_W-1:0] CFG_ENTRY_MOTION    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_EXIT_STEP       = 3'd2;
    localparam logic [IDX_W-1:0] CFG_AWAY_QUIET      = 3'd3;
    localparam logic [IDX_W-1:0] CFG_AWAY_REVERT     = 3'd4;

    localparam logic [WIN_W-1:0] RST_UNLOCK_TO_SENSE = 31'd10000;
    localparam logic [WIN_W-1:0] RST_ENTRY_MOTION    = 31'd30000;
    localparam logic [WIN_W-1:0] RST_EXIT_STEP       = 31'd30000;
    localparam logic [WIN_W-1:0] RST_AWAY_QUIET      = 31'd60000;
    localparam logic [WIN_W-1:0] RST_AWAY_REVERT     = 31'd60000;

    typedef struct packed {
        logic [WIN_W-1:0] unlock_to_sense;
        logic [WIN_W-1:0] entry_motion;
        logic [WIN_W-1:0] exit_step;
        logic [WIN_W-1:0] away_quiet;
        logic [WIN_W-1:0] away_revert;
    } ost_windows_t;

    typedef struct packed {
        ost_presence_t     presence;
        logic              home_flag;
        ost_entry_t        entry_stage;
        logic [TIME_W-1:0] entry_deadline;
        ost_exit_t         exit_stage;
        logic [TIME_W-1:0] exit_deadline;
        logic [TIME_W-1:0] away_since;
    } ost_state_t;

endpackage
`default_nettype wire

// ===== hdl/ost_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event channel
// Valid/ready channel carrying one timestamped sensor event per word.
// ----------------------------------------------------------------------------
interface ost_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [31:0] now_time;
    logic        set_home;

    modport source (output valid, output mode, output now_time, output set_home,
                    input ready);
    modport sink (input valid, input mode, input now_time, input set_home,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/ost_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Status channel
// Valid/ready channel carrying the occupancy status after each event.
// ----------------------------------------------------------------------------
interface ost_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] presence;
    logic       someone_home;
    logic [1:0] entry_step;
    logic [1:0] exit_step;

    modport source (output valid, output presence, output someone_home,
                    output entry_step, output exit_step, input ready);
    modport sink (input valid, input presence, input someone_home,
                  input entry_step, input exit_step, output ready);
endinterface
`default_nettype wire

// ===== hdl/ost_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Occupancy state update
// Works out the next tracker state from the current state and one event.
// ----------------------------------------------------------------------------
module ost_update
    import ost_pkg::*;
(
    input  wire ost_state_t        cur,
    input  wire ost_windows_t      win,
    input  wire logic [2:0]        mode,
    input  wire logic [TIME_W-1:0] now_time,
    input  wire logic              set_home,
    output      ost_state_t        nxt
);

    // Signed wrapping difference now - deadline is at least zero.
    function automatic logic reached(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] dl);
        logic [TIME_W-1:0] d;
        d = now - dl;
        return ~d[TIME_W-1];
    endfunction

    // Signed wrapping difference now - deadline is at most zero.
    function automatic logic in_time(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] dl);
        logic [TIME_W-1:0] d;
        d = now - dl;
        return (d == '0) || d[TIME_W-1];
    endfunction

    function automatic logic [TIME_W-1:0] add_win(input logic [TIME_W-1:0] t,
                                                  input logic [WIN_W-1:0] w);
        return t + {1'b0, w};
    endfunction

    logic revert_open;

    assign revert_open = ~reached(now_time, add_win(cur.away_since, win.away_revert));

    always_comb
    begin
        nxt = cur;
        case (ost_mode_t'(mode))
            MODE_TICK:
            begin
                if (cur.entry_stage != ENTRY_IDLE && reached(now_time, cur.entry_deadline))
                begin
                    nxt.entry_stage    = ENTRY_IDLE;
                    nxt.entry_deadline = '0;
                end
                if (cur.exit_stage != EXIT_IDLE && reached(now_time, cur.exit_deadline))
                begin
                    if (cur.exit_stage == EXIT_WAIT_QUIET)
                    begin
                        nxt.presence   = PRES_AWAY;
                        nxt.home_flag  = 1'b0;
                        nxt.away_since = now_time;
                    end
                    nxt.exit_stage    = EXIT_IDLE;
                    nxt.exit_deadline = '0;
                end
            end
            MODE_UNLOCK:
            begin
                nxt.entry_stage    = ENTRY_WAIT_SENSE;
                nxt.entry_deadline = add_win(now_time, win.unlock_to_sense);
            end
            MODE_ULTRASONIC:
            begin
                if (cur.entry_stage == ENTRY_WAIT_SENSE && in_time(now_time, cur.entry_deadline))
                begin
                    nxt.entry_stage    = ENTRY_WAIT_MOTION;
                    nxt.entry_deadline = add_win(now_time, win.entry_motion);
                end
                nxt.exit_stage    = EXIT_SAW_SENSE;
                nxt.exit_deadline = add_win(now_time, win.exit_step);
            end
            MODE_OPEN:
            begin
                if (cur.exit_stage == EXIT_SAW_SENSE && in_time(now_time, cur.exit_deadline))
                begin
                    nxt.exit_stage    = EXIT_DOOR_OPEN;
                    nxt.exit_deadline = add_win(now_time, win.exit_step);
                end
            end
            MODE_CLOSE:
            begin
                if (cur.exit_stage == EXIT_DOOR_OPEN && in_time(now_time, cur.exit_deadline))
                begin
                    nxt.exit_stage    = EXIT_WAIT_QUIET;
                    nxt.exit_deadline = add_win(now_time, win.away_quiet);
                end
            end
            MODE_MOTION:
            begin
                if (cur.entry_stage == ENTRY_WAIT_MOTION
                    && in_time(now_time, cur.entry_deadline))
                begin
                    nxt.presence       = PRES_HOME;
                    nxt.home_flag      = 1'b1;
                    nxt.entry_stage    = ENTRY_IDLE;
                    nxt.entry_deadline = '0;
                    nxt.exit_stage     = EXIT_IDLE;
                    nxt.exit_deadline  = '0;
                end
                else if (cur.exit_stage == EXIT_WAIT_QUIET
                         || (cur.presence == PRES_AWAY && revert_open))
                begin
                    nxt.presence      = PRES_HOME;
                    nxt.home_flag     = 1'b1;
                    nxt.exit_stage    = EXIT_IDLE;
                    nxt.exit_deadline = '0;
                end
            end
            MODE_EXT_SET:
            begin
                nxt.presence  = set_home ? PRES_HOME : PRES_AWAY;
                nxt.home_flag = set_home;
                if (!set_home)
                begin
                    nxt.away_since = now_time;
                end
                nxt.entry_stage    = ENTRY_IDLE;
                nxt.entry_deadline = '0;
                nxt.exit_stage     = EXIT_IDLE;
                nxt.exit_deadline  = '0;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/occupancy_sequence_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Occupancy sequence tracker
// Follows entry and exit door sequences and reports whether the home is
// occupied after every sensor event.
// ----------------------------------------------------------------------------
// Events arrive as words on the evt channel and one status word leaves on
// the status channel for each of them, in order. An accepted event sits in
// an input register, the state update is worked out from it and the status
// word is registered together with the new state, so the status word becomes
// valid once the event has passed the input register and the state register.
// One event can be taken every cycle while the receiver does not stall,
// limited only by the single state update that each event needs before the
// next one reads the state. While the receiver stalls, the status word is
// held and one further event waits in the input register; evt.ready falls
// only once both are full. Reset clears both registers and sets presence
// to unknown with the home flag raised, both sequences idle and all windows
// to defaults. Windows are written through cfg_write/cfg_index/cfg_data;
// the user must write them only while idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module occupancy_sequence_tracker
    import ost_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [WIN_W-1:0]  cfg_data,
    ost_in_if.sink                 evt,
    ost_out_if.source              status
);

    ost_windows_t      win_reg;
    ost_state_t        state_reg;
    ost_state_t        state_next;

    logic              in_valid_reg;
    logic [2:0]        in_mode_reg;
    logic [TIME_W-1:0] in_time_reg;
    logic              in_set_home_reg;

    logic              out_valid_reg;
    logic              advance;
    logic              take_in;

    assign advance = in_valid_reg && (!out_valid_reg || status.ready);
    assign take_in = evt.valid && evt.ready;
    assign evt.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.unlock_to_sense <= RST_UNLOCK_TO_SENSE;
            win_reg.entry_motion    <= RST_ENTRY_MOTION;
            win_reg.exit_step       <= RST_EXIT_STEP;
            win_reg.away_quiet      <= RST_AWAY_QUIET;
            win_reg.away_revert     <= RST_AWAY_REVERT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_UNLOCK_TO_SENSE: win_reg.unlock_to_sense <= cfg_data;
                CFG_ENTRY_MOTION:    win_reg.entry_motion    <= cfg_data;
                CFG_EXIT_STEP:       win_reg.exit_step       <= cfg_data;
                CFG_AWAY_QUIET:      win_reg.away_quiet      <= cfg_data;
                CFG_AWAY_REVERT:     win_reg.away_revert     <= cfg_data;
                default:             win_reg                 <= win_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (evt.ready)
        begin
            in_valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_mode_reg     <= evt.mode;
            in_time_reg     <= evt.now_time;
            in_set_home_reg <= evt.set_home;
        end
    end

    ost_update u_update (
        .cur      (state_reg),
        .win      (win_reg),
        .mode     (in_mode_reg),
        .now_time (in_time_reg),
        .set_home (in_set_home_reg),
        .nxt      (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.presence       <= PRES_UNKNOWN;
            state_reg.home_flag      <= 1'b1;
            state_reg.entry_stage    <= ENTRY_IDLE;
            state_reg.entry_deadline <= '0;
            state_reg.exit_stage     <= EXIT_IDLE;
            state_reg.exit_deadline  <= '0;
            state_reg.away_since     <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // The status word is the registered state itself, taken after the update.
    assign status.valid        = out_valid_reg;
    assign status.presence     = state_reg.presence;
    assign status.someone_home = state_reg.home_flag;
    assign status.entry_step   = state_reg.entry_stage;
    assign status.exit_step    = state_reg.exit_stage;

endmodule
`default_nettype wire
